FILE: rtl/core/msbrd_pkg.sv
// msbrd_pkg: shared types and constants of the msb-first bit reader
// operation and status codes, queue command/status groups, result beat
// no dependencies
package msbrd_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned BytesW = 4;
  localparam int unsigned CountW = 7;

  localparam logic [CountW-1:0] MaxCount = 7'd64;
  localparam logic [BytesW-1:0] MaxBytes = 4'd8;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_COUNT = 3'd1,
    ST_NO_DATA   = 3'd2,
    ST_CLOSED    = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // requests from the unpacker to the word queue
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } q_cmd_t;

  // word queue occupancy as seen by the unpacker
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } q_stat_t;

  typedef struct packed {
    logic [WordW-1:0] data;
    status_e          status;
    logic             more;
  } res_t;

endpackage

FILE: rtl/core/msbrd_queue.sv
// msbrd_queue: word queue in a synchronous memory with a prefetched head entry
// the read port always fetches the entry the head pointer will point at next
// depends on msbrd_pkg
module msbrd_queue #(
  parameter int unsigned WORD_QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msbrd_pkg::q_cmd_t              cmd_i,
  input  logic [msbrd_pkg::WordW-1:0]    push_data_i,
  input  logic [msbrd_pkg::BytesW-1:0]   push_bytes_i,
  output msbrd_pkg::q_stat_t             stat_o,
  output logic [msbrd_pkg::WordW-1:0]    head_data_o,
  output logic [msbrd_pkg::BytesW-1:0]   head_bytes_o
);

  localparam int unsigned PtrW   = (WORD_QUEUE_DEPTH > 1) ? $clog2(WORD_QUEUE_DEPTH) : 1;
  localparam int unsigned FillW  = $clog2(WORD_QUEUE_DEPTH + 1);
  localparam int unsigned EntryW = msbrd_pkg::WordW + msbrd_pkg::BytesW;

  localparam logic [PtrW-1:0]  LastPtr  = PtrW'(WORD_QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(WORD_QUEUE_DEPTH);
  localparam logic [FillW-1:0] OneFill  = FillW'(1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  logic [EntryW-1:0] mem_q [WORD_QUEUE_DEPTH];
  logic [EntryW-1:0] rd_q;
  logic [EntryW-1:0] wr_entry;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              fwd;

  assign wr_entry = {push_data_i, push_bytes_i};

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (cmd_i.flush) begin
      head_d = tail_q;
      fill_d = '0;
    end else if (cmd_i.pop) begin
      head_d = ptr_inc(head_q);
      fill_d = fill_q - 1'b1;
    end else if (cmd_i.push) begin
      tail_d = ptr_inc(tail_q);
      fill_d = fill_q + 1'b1;
    end
  end

  // a word written to the entry being fetched is forwarded straight in
  assign fwd = cmd_i.push && (tail_q == head_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= wr_entry;
    end
    rd_q <= fwd ? wr_entry : mem_q[head_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  assign stat_o.empty  = (fill_q == '0);
  assign stat_o.full   = (fill_q == FullFill);
  assign stat_o.single = (fill_q == OneFill);
  assign head_data_o   = rd_q[EntryW-1:msbrd_pkg::BytesW];
  assign head_bytes_o  = rd_q[msbrd_pkg::BytesW-1:0];

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("word queue fill count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("push into full word queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stat_o.empty)
    else $error("pop from empty word queue");

  a_fwd_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && stat_o.empty && !cmd_i.flush |=> rd_q == $past(wr_entry))
    else $error("pushed word not forwarded to empty queue head");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> stat_o.empty)
    else $error("queue not empty after flush");

endmodule

FILE: rtl/core/msbrd_unpack.sv
// msbrd_unpack: current word, bit count and closed flag; decodes each beat
// and extracts bits through a two-word window shifter
// depends on msbrd_pkg
module msbrd_unpack (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  msbrd_pkg::op_e                 op_i,
  input  logic [msbrd_pkg::BytesW-1:0]   word_bytes_i,
  input  logic [msbrd_pkg::CountW-1:0]   bit_count_i,
  input  msbrd_pkg::q_stat_t             stat_i,
  input  logic [msbrd_pkg::WordW-1:0]    head_data_i,
  input  logic [msbrd_pkg::BytesW-1:0]   head_bytes_i,
  output msbrd_pkg::q_cmd_t              cmd_o,
  output msbrd_pkg::res_t                res_o
);

  logic [msbrd_pkg::WordW-1:0]    cur_q, cur_d;
  logic [msbrd_pkg::CountW-1:0]   bl_q, bl_d;
  logic                           closed_q, closed_d;

  logic                           cnt_ok, bytes_ok;
  logic [msbrd_pkg::CountW-1:0]   nb;
  logic [msbrd_pkg::CountW:0]     avail;
  logic [msbrd_pkg::CountW-1:0]   shamt_w;
  logic [2*msbrd_pkg::WordW-1:0]  pair;
  logic [msbrd_pkg::WordW-1:0]    pair_sh, mask, bits, head_right;
  logic [msbrd_pkg::CountW-1:0]   mask_sh;
  logic                           q_after;
  msbrd_pkg::q_cmd_t              cmd;
  msbrd_pkg::status_e             status;
  logic [msbrd_pkg::WordW-1:0]    data;

  assign cnt_ok   = (bit_count_i != '0) && (bit_count_i <= msbrd_pkg::MaxCount);
  assign bytes_ok = (word_bytes_i != '0) && (word_bytes_i <= msbrd_pkg::MaxBytes);

  // bits available in the head word, zero when the queue is empty
  assign nb    = stat_i.empty ? '0 : {head_bytes_i, 3'b000};
  assign avail = {1'b0, bl_q} + {1'b0, nb};

  // window over unread tail of current word followed by the head word
  // shift amount wraps modulo 128, which keeps 64 + bits left - count exact
  assign shamt_w = msbrd_pkg::MaxCount + bl_q - bit_count_i;
  assign pair    = {cur_q, head_data_i};
  assign pair_sh = msbrd_pkg::WordW'(pair >> shamt_w);
  assign mask_sh = msbrd_pkg::MaxCount - bit_count_i;
  assign mask    = {msbrd_pkg::WordW{1'b1}} >> mask_sh;
  assign bits    = pair_sh & mask;

  assign head_right = head_data_i >> (msbrd_pkg::MaxCount - nb);

  always_comb begin
    cmd      = '0;
    status   = msbrd_pkg::ST_OK;
    data     = '0;
    cur_d    = cur_q;
    bl_d     = bl_q;
    closed_d = closed_q;
    q_after  = !stat_i.empty;
    case (op_i)
      msbrd_pkg::OP_PUSH: begin
        if (!bytes_ok) begin
          status = msbrd_pkg::ST_BAD_COUNT;
        end else if (stat_i.full) begin
          status = msbrd_pkg::ST_FULL;
        end else begin
          cmd.push = 1'b1;
          q_after  = 1'b1;
        end
      end
      msbrd_pkg::OP_READ: begin
        if (!cnt_ok) begin
          status = msbrd_pkg::ST_BAD_COUNT;
        end else if (closed_q) begin
          status = msbrd_pkg::ST_CLOSED;
        end else if (bit_count_i <= bl_q) begin
          data = bits;
          bl_d = bl_q - bit_count_i;
        end else if ({1'b0, bit_count_i} > avail) begin
          status = msbrd_pkg::ST_NO_DATA;
        end else begin
          // spans into the head word, which becomes the current word
          data    = bits;
          cmd.pop = 1'b1;
          cur_d   = head_right;
          bl_d    = msbrd_pkg::CountW'(avail - {1'b0, bit_count_i});
          q_after = !stat_i.single;
        end
      end
      msbrd_pkg::OP_CLOSE: begin
        if (!closed_q) begin
          closed_d  = 1'b1;
          bl_d      = '0;
          cur_d     = '0;
          cmd.flush = 1'b1;
          q_after   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_o         = accept_i ? cmd : '0;
  assign res_o.data    = data;
  assign res_o.status  = status;
  assign res_o.more    = !closed_d && ((bl_d != '0) || q_after);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      bl_q     <= '0;
      closed_q <= 1'b0;
    end else if (accept_i) begin
      cur_q    <= cur_d;
      bl_q     <= bl_d;
      closed_q <= closed_d;
    end
  end

  a_bl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_q <= msbrd_pkg::MaxCount)
    else $error("bit count of current word out of range");

  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> bl_q == '0)
    else $error("closed stream still holds unread bits");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed flag dropped");

endmodule

FILE: rtl/core/msbrd_out_buf.sv
// msbrd_out_buf: two-entry result buffer between the unpacker and the output
// ready toward the input depends only on registered state
// depends on msbrd_pkg
module msbrd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  msbrd_pkg::res_t  res_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output msbrd_pkg::res_t  res_o
);

  msbrd_pkg::res_t main_q, skid_q;
  logic            main_valid_q, skid_valid_q;
  logic            fire;

  assign fire    = main_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign res_o   = main_q;

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (fire) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || fire) begin
        main_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || fire) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (fire) begin
      main_valid_q <= 1'b0;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without main entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result beat pushed into full buffer");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && fire |=> main_valid_q && main_q == $past(skid_q))
    else $error("skid entry not moved to output in order");

endmodule

FILE: rtl/core/msb_first_bit_reader.sv
// msb_first_bit_reader: top level of the msb-first bit reader
// Takes one beat per clock cycle while the result buffer has room: push a word,
// read 1 to 64 bits, or close. Each beat gives one result beat, registered in
// the result buffer on acceptance; a two-entry result buffer lets input continue
// while a result waits. Pushed words sit in a WORD_QUEUE_DEPTH-entry
// memory whose head entry is prefetched every cycle (writes to the entry
// being fetched are forwarded), so a read spanning into the next word
// needs no separate fetch. There is no clearing pass after reset. Failed
// items consume nothing; read_data is zero unless a read succeeds.
// depends on msbrd_pkg, msbrd_queue, msbrd_unpack, msbrd_out_buf
module msb_first_bit_reader #(
  parameter int unsigned WORD_QUEUE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [63:0]                  word_data_i,
  input  logic [3:0]                   word_bytes_i,
  input  logic [6:0]                   bit_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  read_data_o,
  output logic [2:0]                   status_o,
  output logic                         more_available_o
);

  logic                                accept;
  msbrd_pkg::q_cmd_t                   q_cmd;
  msbrd_pkg::q_stat_t                  q_stat;
  logic [msbrd_pkg::WordW-1:0]         head_data;
  logic [msbrd_pkg::BytesW-1:0]        head_bytes;
  msbrd_pkg::res_t                     res, res_out;

  assign accept = in_valid_i && in_ready_o;

  msbrd_queue #(
    .WORD_QUEUE_DEPTH (WORD_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_cmd),
    .push_data_i  (word_data_i),
    .push_bytes_i (word_bytes_i),
    .stat_o       (q_stat),
    .head_data_o  (head_data),
    .head_bytes_o (head_bytes)
  );

  msbrd_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (msbrd_pkg::op_e'(operation_i)),
    .word_bytes_i (word_bytes_i),
    .bit_count_i  (bit_count_i),
    .stat_i       (q_stat),
    .head_data_i  (head_data),
    .head_bytes_i (head_bytes),
    .cmd_o        (q_cmd),
    .res_o        (res)
  );

  msbrd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign read_data_o      = res_out.data;
  assign status_o         = res_out.status;
  assign more_available_o = res_out.more;

endmodule

FILE: test/msbrd_checker.sv
// msbrd_checker: watches both channels of the msb-first bit reader, predicts
// every result beat and compares it field by field with what the block returns
// depends on msbrd_pkg
module msbrd_checker #(
  parameter int unsigned Depth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   operation_i,
  input  logic [msbrd_pkg::WordW-1:0]  word_data_i,
  input  logic [msbrd_pkg::BytesW-1:0] word_bytes_i,
  input  logic [msbrd_pkg::CountW-1:0] bit_count_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [msbrd_pkg::WordW-1:0]  read_data_i,
  input  logic [2:0]                   status_i,
  input  logic                         more_available_i,
  output int unsigned                  owed_o,
  output int unsigned                  mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the reader state
  logic [msbrd_pkg::WordW-1:0]  words [Depth];
  logic [msbrd_pkg::BytesW-1:0] word_len [Depth];
  int unsigned                  head;
  int unsigned                  tail;
  int unsigned                  fill;
  logic [msbrd_pkg::WordW-1:0]  cur_word;
  int unsigned                  bits_left;
  logic                         closed;

  msbrd_pkg::res_t owed_results [$];
  int unsigned     mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic logic [msbrd_pkg::WordW-1:0] low_ones(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [msbrd_pkg::WordW-1:0] got,
                               input logic [msbrd_pkg::WordW-1:0] want);
    $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // applies one input beat to the shadow state and yields its result beat
  task automatic advance_reader(input msbrd_pkg::op_e op,
                                input logic [msbrd_pkg::WordW-1:0] data,
                                input logic [msbrd_pkg::BytesW-1:0] nbytes,
                                input logic [msbrd_pkg::CountW-1:0] count,
                                output msbrd_pkg::res_t res);
    int unsigned                 nb;
    int unsigned                 need;
    int unsigned                 cnt;
    logic [msbrd_pkg::WordW-1:0] w;
    cnt        = 32'(count);
    res.data   = '0;
    res.status = msbrd_pkg::ST_OK;
    case (op)
      msbrd_pkg::OP_PUSH: begin
        if (nbytes == '0 || nbytes > msbrd_pkg::MaxBytes) begin
          res.status = msbrd_pkg::ST_BAD_COUNT;
        end else if (fill >= Depth) begin
          res.status = msbrd_pkg::ST_FULL;
        end else begin
          words[tail]    = data;
          word_len[tail] = nbytes;
          tail           = (tail + 1) % Depth;
          fill++;
        end
      end
      msbrd_pkg::OP_READ: begin
        if (count == '0 || count > msbrd_pkg::MaxCount) begin
          res.status = msbrd_pkg::ST_BAD_COUNT;
        end else if (closed) begin
          res.status = msbrd_pkg::ST_CLOSED;
        end else if (cnt <= bits_left) begin
          res.data  = (cur_word >> (bits_left - cnt)) & low_ones(cnt);
          bits_left = bits_left - cnt;
        end else begin
          nb = (fill == 0) ? 0 : 8 * word_len[head];
          // only the head word may top up the current one
          if (cnt > bits_left + nb) begin
            res.status = msbrd_pkg::ST_NO_DATA;
          end else begin
            need     = cnt - bits_left;
            w        = (nb >= 64) ? words[head] : words[head] >> (64 - nb);
            res.data = (need >= 64) ? '0 : (cur_word & low_ones(bits_left)) << need;
            res.data |= (w >> (nb - need)) & low_ones(need);
            cur_word  = w;
            bits_left = nb - need;
            head      = (head + 1) % Depth;
            fill--;
          end
        end
      end
      msbrd_pkg::OP_CLOSE: begin
        if (!closed) begin
          closed    = 1'b1;
          bits_left = 0;
          cur_word  = '0;
          fill      = 0;
          head      = tail;
        end
      end
      default: ;
    endcase
    res.more = !closed && (bits_left > 0 || fill > 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    msbrd_pkg::res_t want;
    if (!rst_ni) begin
      head      = 0;
      tail      = 0;
      fill      = 0;
      cur_word  = '0;
      bits_left = 0;
      closed    = 1'b0;
      owed_results.delete();
      owed_o <= 0;
    end else begin
      // output first, so a beat racing its own input is never excused
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("unowed result beat", read_data_i, '0);
        end else begin
          want = owed_results.pop_front();
          if (read_data_i !== want.data)
            flag_mismatch("read_data", read_data_i, want.data);
          if (status_i !== want.status)
            flag_mismatch("status", 64'(status_i), 64'(want.status));
          if (more_available_i !== want.more)
            flag_mismatch("more_available", 64'(more_available_i), 64'(want.more));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_reader(msbrd_pkg::op_e'(operation_i), word_data_i, word_bytes_i,
                       bit_count_i, want);
        owed_results.push_back(want);
      end
      owed_o <= unsigned'(owed_results.size());
    end
  end

endmodule

FILE: test/msb_first_bit_reader_tb.sv
// msb_first_bit_reader_tb: drives push, read and close beats into the bit reader
// with random gaps and stalls, and leaves prediction to msbrd_checker
// depends on msbrd_pkg, msbrd_checker and the msb_first_bit_reader rtl
module msb_first_bit_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned RandomBeats = 450;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic                         in_ready;
  logic [1:0]                   operation  = msbrd_pkg::OP_NOP;
  logic [msbrd_pkg::WordW-1:0]  word_data  = '0;
  logic [msbrd_pkg::BytesW-1:0] word_bytes = '0;
  logic [msbrd_pkg::CountW-1:0] bit_count  = '0;
  logic                         out_valid;
  logic                         out_ready  = 1'b0;
  logic [msbrd_pkg::WordW-1:0]  read_data;
  logic [2:0]                   status;
  logic                         more_available;
  logic                         calm       = 1'b0;
  int unsigned                  owed;
  int unsigned                  mismatches;

  always #4 clk = ~clk;

  msb_first_bit_reader #(
    .WORD_QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .word_data_i     (word_data),
    .word_bytes_i    (word_bytes),
    .bit_count_i     (bit_count),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .read_data_o     (read_data),
    .status_o        (status),
    .more_available_o(more_available)
  );

  msbrd_checker #(
    .Depth(QueueDepth)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .operation_i     (operation),
    .word_data_i     (word_data),
    .word_bytes_i    (word_bytes),
    .bit_count_i     (bit_count),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .read_data_i     (read_data),
    .status_i        (status),
    .more_available_i(more_available),
    .owed_o          (owed),
    .mismatches_o    (mismatches)
  );

  // result side stalls at random outside the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  task automatic send_beat(input msbrd_pkg::op_e op,
                           input logic [msbrd_pkg::WordW-1:0] data,
                           input logic [msbrd_pkg::BytesW-1:0] nbytes,
                           input logic [msbrd_pkg::CountW-1:0] count);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    word_data  <= data;
    word_bytes <= nbytes;
    bit_count  <= count;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [msbrd_pkg::WordW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // mostly well-formed pushes and reads, with a few bad counts and no-ops
  task automatic send_random_beat();
    int unsigned                  pick;
    int unsigned                  sel;
    logic [msbrd_pkg::BytesW-1:0] nbytes;
    logic [msbrd_pkg::CountW-1:0] count;
    pick = $urandom_range(99);
    sel  = $urandom_range(19);
    if (pick < 46) begin
      if (sel == 0) nbytes = $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
      else nbytes = 4'($urandom_range(1, 8));
      send_beat(msbrd_pkg::OP_PUSH, rand_word(), nbytes, 7'($urandom()));
    end else if (pick < 96) begin
      if (sel == 0) count = $urandom_range(1) ? 7'd0 : 7'($urandom_range(65, 127));
      else if (sel < 4) count = $urandom_range(1) ? 7'd1 : msbrd_pkg::MaxCount;
      else if (sel < 8) count = 7'(8 * $urandom_range(1, 8));
      else count = 7'($urandom_range(1, 64));
      send_beat(msbrd_pkg::OP_READ, rand_word(), 4'($urandom()), count);
    end else begin
      send_beat(msbrd_pkg::OP_NOP, rand_word(), 4'($urandom()), 7'($urandom()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad counts and a read of an empty stream
    send_beat(msbrd_pkg::OP_READ, '0, 4'd8, 7'd0);
    send_beat(msbrd_pkg::OP_READ, '1, 4'd8, 7'd127);
    send_beat(msbrd_pkg::OP_READ, '0, 4'd8, 7'd8);
    send_beat(msbrd_pkg::OP_PUSH, '1, 4'd0, 7'd8);
    send_beat(msbrd_pkg::OP_PUSH, '1, 4'd15, 7'd8);
    // fill the queue, then one push too many
    for (int i = 0; i < QueueDepth; i++) begin
      if (i == 0) send_beat(msbrd_pkg::OP_PUSH, '1, 4'd8, 7'd0);
      else if (i == 1) send_beat(msbrd_pkg::OP_PUSH, '0, 4'd1, 7'd0);
      else send_beat(msbrd_pkg::OP_PUSH, rand_word(), 4'(1 + i % 8), 7'd0);
    end
    send_beat(msbrd_pkg::OP_PUSH, rand_word(), 4'd8, 7'd0);
    // whole first word, then more than the one-byte head word holds
    send_beat(msbrd_pkg::OP_READ, '0, 4'd0, msbrd_pkg::MaxCount);
    send_beat(msbrd_pkg::OP_READ, '0, 4'd0, 7'd9);
    send_beat(msbrd_pkg::OP_NOP, '1, 4'd15, 7'd127);

    for (int n = 0; n < RandomBeats; n++) begin
      calm <= (n >= 150 && n < 250);
      send_random_beat();
    end
    calm <= 1'b0;

    // closing is final, so its cases come last
    send_beat(msbrd_pkg::OP_CLOSE, '0, 4'd0, 7'd0);
    send_beat(msbrd_pkg::OP_READ, '0, 4'd0, 7'd8);
    send_beat(msbrd_pkg::OP_READ, '0, 4'd0, 7'd0);
    send_beat(msbrd_pkg::OP_PUSH, rand_word(), 4'd8, 7'd0);
    send_beat(msbrd_pkg::OP_CLOSE, '1, 4'd15, 7'd127);
    send_beat(msbrd_pkg::OP_READ, '0, 4'd0, msbrd_pkg::MaxCount);
    in_valid <= 1'b0;

    do @(posedge clk); while (owed != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("msb_first_bit_reader regression: pass");
    end else begin
      $display("msb_first_bit_reader regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("msb_first_bit_reader regression: fail");
    $finish;
  end

endmodule
